// File: rtl/isms_pkg.sv
// Shared types and codes for the interval set merge/split unit.
package isms_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_BUILD,
      ST_PAD,
      ST_COPY,
      ST_LIST,
      ST_RESTORE
   } isms_state_type;

   typedef logic [1:0] req_kind_type;
   localparam req_kind_type REQ_ADD    = 2'd0;
   localparam req_kind_type REQ_REMOVE = 2'd1;
   localparam req_kind_type REQ_CLEAR  = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_OVERFLOW = 2'd1;
   localparam status_type STATUS_ORDER    = 2'd2;

   // Per-cycle control of one chain of cells.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

// File: rtl/isms_cell.sv
// One interval cell: holds a bound pair, shifts from its neighbor or loads in parallel.
module isms_cell #(
   parameter int BOUND_WIDTH = 32
) (
   input  logic                          clock,
   input  isms_pkg::cell_ctrl_type       ctrl,
   input  logic signed [BOUND_WIDTH-1:0] nbr_lo,
   input  logic signed [BOUND_WIDTH-1:0] nbr_hi,
   input  logic signed [BOUND_WIDTH-1:0] load_lo,
   input  logic signed [BOUND_WIDTH-1:0] load_hi,
   output logic signed [BOUND_WIDTH-1:0] lo,
   output logic signed [BOUND_WIDTH-1:0] hi
);

   logic signed [BOUND_WIDTH-1:0] lo_ff;
   logic signed [BOUND_WIDTH-1:0] hi_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         lo_ff <= load_lo;
         hi_ff <= load_hi;
      end else if (ctrl.shift) begin
         lo_ff <= nbr_lo;
         hi_ff <= nbr_hi;
      end
   end

   assign lo = lo_ff;
   assign hi = hi_ff;

endmodule

// File: rtl/interval_set_merge_split_unit.sv
// Top level of the interval set merge/split unit: control sequencer and two cell chains.
//
// The unit keeps a sorted set of closed intervals in a chain of cells. One request
// enters on the req_ stream: tuser carries the request kind and the defined flag,
// tdata the low and high bounds. Add merges the range into the set, remove cuts it
// out, clear empties the set. After every request the unit lists the whole set on
// the rsp_ stream, one response per stored interval (or a single empty response),
// with tlast on the final one.
// A request is handled in passes over the store chain: a scan pass, a decision
// state, a rebuild and padding pass that leaves the new list at the head of the
// build chain, a copy state, and a listing pass that emits and then rotates the
// store chain back. A clear, or a request rejected on arrival, goes straight to the
// listing pass, and a request dropped after the scan skips the rebuild.
// req_tready is high only while the unit waits for a request. Results leave through
// an output register, so a stalled receiver simply holds the listing pass where it
// is. Reset empties the set and returns the sequencer to idle.
module interval_set_merge_split_unit #(
   parameter int MAX_INTERVALS = 16,
   parameter int BOUND_WIDTH   = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // tdata: range_low, range_high (then zero fill)
   input  logic [((2*BOUND_WIDTH+7)/8)*8-1:0] req_tdata,
   // tuser: req_type [1:0], range_defined [2]
   input  logic [2:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata: changed, status, entry_index, entry_low, entry_high, entry_count (then zero fill)
   output logic [((3+$clog2(MAX_INTERVALS)+2*BOUND_WIDTH+$clog2(MAX_INTERVALS+1)+7)/8)*8-1:0]
      rsp_tdata,
   // tuser: entry_valid
   output logic rsp_tuser,
   output logic rsp_tlast
);

   import isms_pkg::*;

   localparam int IDX_W  = $clog2(MAX_INTERVALS);
   localparam int CNT_W  = $clog2(MAX_INTERVALS + 1);
   localparam int SUM_W  = $clog2(2 * MAX_INTERVALS + 1);
   localparam int OUT_W  = ((3 + IDX_W + 2 * BOUND_WIDTH + CNT_W + 7) / 8) * 8;
   localparam int B      = BOUND_WIDTH;

   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_INTERVALS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_INTERVALS - 1);
   localparam logic [SUM_W-1:0] SUM_MAX  = SUM_W'(MAX_INTERVALS);

   isms_state_type state_ff, state_in;

   req_kind_type           kind_ff, kind_in;
   logic signed [B-1:0]    a_ff, a_in, b_ff, b_in;
   logic signed [B-1:0]    na_ff, na_in, nb_ff, nb_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0]       newn_ff, newn_in;
   logic [CNT_W-1:0]       step_ff, step_in;
   logic [CNT_W-1:0]       wr_ff, wr_in;
   logic [SUM_W-1:0]       keep_ff, keep_in;
   logic                   inside_ff, inside_in;
   logic                   any_ff, any_in;
   logic                   phase_ff, phase_in;
   logic                   placed_ff, placed_in;
   logic                   chg_ff, chg_in;
   status_type             status_ff, status_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                   rsp_user_ff, rsp_user_in;
   logic                   rsp_last_ff, rsp_last_in;

   // Cell chains.
   logic signed [B-1:0] st_lo [MAX_INTERVALS];
   logic signed [B-1:0] st_hi [MAX_INTERVALS];
   logic signed [B-1:0] bd_lo [MAX_INTERVALS];
   logic signed [B-1:0] bd_hi [MAX_INTERVALS];
   cell_ctrl_type       st_ctrl, bd_ctrl;
   logic signed [B-1:0] emit_lo, emit_hi;

   // Incoming request fields.
   req_kind_type        req_kind;
   logic                req_def;
   logic signed [B-1:0] req_lo, req_hi;

   // Head cell classification.
   logic signed [B-1:0] head_lo, head_hi;
   logic                head_v, covered, overlap, truly, greater, rsp_slot;

   assign req_kind = req_tuser[1:0];
   assign req_def  = req_tuser[2];
   assign req_lo   = req_tdata[B-1:0];
   assign req_hi   = req_tdata[2*B-1:B];

   assign head_lo  = st_lo[0];
   assign head_hi  = st_hi[0];
   assign head_v   = (step_ff < cnt_ff);
   assign covered  = (a_ff <= head_lo) && (head_hi <= b_ff);
   assign overlap  = (a_ff <= head_hi) && (head_lo <= b_ff);
   // True overlap: the intersection has positive length.
   assign truly    = ((head_lo > a_ff) ? head_lo : a_ff) < ((head_hi < b_ff) ? head_hi : b_ff);
   assign greater  = (head_lo > na_ff) || ((head_lo == na_ff) && (head_hi > nb_ff));
   assign rsp_slot = !rsp_valid_ff || rsp_tready;

   genvar k;
   generate
      for (k = 0; k < MAX_INTERVALS; k++) begin : g_cells
         logic signed [B-1:0] st_nlo, st_nhi, bd_nlo, bd_nhi;
         if (k == MAX_INTERVALS - 1) begin : g_tail
            // The store chain rotates; the build chain takes the emitted interval.
            assign st_nlo = st_lo[0];
            assign st_nhi = st_hi[0];
            assign bd_nlo = emit_lo;
            assign bd_nhi = emit_hi;
         end else begin : g_body
            assign st_nlo = st_lo[k+1];
            assign st_nhi = st_hi[k+1];
            assign bd_nlo = bd_lo[k+1];
            assign bd_nhi = bd_hi[k+1];
         end
         isms_cell #(.BOUND_WIDTH(B)) u_store (
            .clock   (clock),
            .ctrl    (st_ctrl),
            .nbr_lo  (st_nlo),
            .nbr_hi  (st_nhi),
            .load_lo (bd_lo[k]),
            .load_hi (bd_hi[k]),
            .lo      (st_lo[k]),
            .hi      (st_hi[k])
         );
         isms_cell #(.BOUND_WIDTH(B)) u_build (
            .clock   (clock),
            .ctrl    (bd_ctrl),
            .nbr_lo  (bd_nlo),
            .nbr_hi  (bd_nhi),
            .load_lo (bd_nlo),
            .load_hi (bd_nhi),
            .lo      (bd_lo[k]),
            .hi      (bd_hi[k])
         );
      end
   endgenerate

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if ((req_kind == REQ_ADD || req_kind == REQ_REMOVE) && req_def
                   && !(req_lo > req_hi)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_LIST;
               end
            end
         end
         ST_SCAN: begin
            if (step_ff == CNT_LAST) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (kind_ff == REQ_ADD) begin
               if (inside_ff || keep_ff >= SUM_MAX) state_in = ST_LIST;
               else state_in = ST_BUILD;
            end else begin
               if (!any_ff || keep_ff > SUM_MAX) state_in = ST_LIST;
               else state_in = ST_BUILD;
            end
         end
         ST_BUILD: begin
            if (!head_v && (kind_ff != REQ_ADD || placed_ff)) state_in = ST_PAD;
         end
         ST_PAD: begin
            if (wr_ff == CNT_MAX) state_in = ST_COPY;
         end
         ST_COPY: begin
            state_in = ST_LIST;
         end
         ST_LIST: begin
            if (rsp_slot) begin
               if (cnt_ff == '0) state_in = ST_IDLE;
               else if (step_ff == cnt_ff - CNT_W'(1)) begin
                  state_in = (step_ff == CNT_LAST) ? ST_IDLE : ST_RESTORE;
               end
            end
         end
         ST_RESTORE: begin
            if (step_ff == CNT_LAST) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and chain control.
   always_comb begin
      kind_in      = kind_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      na_in        = na_ff;
      nb_in        = nb_ff;
      cnt_in       = cnt_ff;
      newn_in      = newn_ff;
      step_in      = step_ff;
      wr_in        = wr_ff;
      keep_in      = keep_ff;
      inside_in    = inside_ff;
      any_in       = any_ff;
      phase_in     = phase_ff;
      placed_in    = placed_ff;
      chg_in       = chg_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      st_ctrl      = '0;
      bd_ctrl      = '0;
      emit_lo      = '0;
      emit_hi      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_kind;
               a_in      = req_lo;
               b_in      = req_hi;
               na_in     = req_lo;
               nb_in     = req_hi;
               step_in   = '0;
               keep_in   = '0;
               inside_in = 1'b0;
               any_in    = 1'b0;
               chg_in    = 1'b0;
               status_in = STATUS_OK;
               if (req_kind == REQ_CLEAR) begin
                  chg_in = (cnt_ff != '0);
                  cnt_in = '0;
               end else if ((req_kind == REQ_ADD || req_kind == REQ_REMOVE) && req_def
                            && (req_lo > req_hi)) begin
                  status_in = STATUS_ORDER;
               end
            end
         end
         ST_SCAN: begin
            st_ctrl.shift = 1'b1;
            step_in = (step_ff == CNT_LAST) ? '0 : step_ff + CNT_W'(1);
            if (head_v) begin
               if (kind_ff == REQ_ADD) begin
                  if ((head_lo <= a_ff) && (b_ff <= head_hi)) inside_in = 1'b1;
                  if (!covered && overlap) begin
                     if (head_lo < na_ff) na_in = head_lo;
                     if (head_hi > nb_ff) nb_in = head_hi;
                  end else if (!covered) begin
                     keep_in = keep_ff + SUM_W'(1);
                  end
               end else begin
                  if (truly) begin
                     any_in  = 1'b1;
                     keep_in = keep_ff + SUM_W'(head_lo < a_ff) + SUM_W'(head_hi > b_ff);
                  end else begin
                     keep_in = keep_ff + SUM_W'(1);
                  end
               end
            end
         end
         ST_DECIDE: begin
            step_in   = '0;
            wr_in     = '0;
            phase_in  = 1'b0;
            placed_in = 1'b0;
            if (kind_ff == REQ_ADD) begin
               if (!inside_ff) begin
                  if (keep_ff >= SUM_MAX) begin
                     status_in = STATUS_OVERFLOW;
                  end else begin
                     chg_in  = 1'b1;
                     newn_in = CNT_W'(keep_ff + SUM_W'(1));
                  end
               end
            end else if (any_ff) begin
               if (keep_ff > SUM_MAX) begin
                  status_in = STATUS_OVERFLOW;
               end else begin
                  chg_in  = 1'b1;
                  newn_in = CNT_W'(keep_ff);
               end
            end
         end
         ST_BUILD: begin
            if (!head_v) begin
               if (kind_ff == REQ_ADD && !placed_ff) begin
                  bd_ctrl.shift = 1'b1;
                  emit_lo       = na_ff;
                  emit_hi       = nb_ff;
                  placed_in     = 1'b1;
                  wr_in         = wr_ff + CNT_W'(1);
               end
            end else if (kind_ff == REQ_ADD) begin
               if (covered || overlap) begin
                  st_ctrl.shift = 1'b1;
                  step_in       = step_ff + CNT_W'(1);
               end else if (!placed_ff && greater) begin
                  bd_ctrl.shift = 1'b1;
                  emit_lo       = na_ff;
                  emit_hi       = nb_ff;
                  placed_in     = 1'b1;
                  wr_in         = wr_ff + CNT_W'(1);
               end else begin
                  bd_ctrl.shift = 1'b1;
                  emit_lo       = head_lo;
                  emit_hi       = head_hi;
                  wr_in         = wr_ff + CNT_W'(1);
                  st_ctrl.shift = 1'b1;
                  step_in       = step_ff + CNT_W'(1);
               end
            end else begin
               if (!truly) begin
                  bd_ctrl.shift = 1'b1;
                  emit_lo       = head_lo;
                  emit_hi       = head_hi;
                  wr_in         = wr_ff + CNT_W'(1);
                  st_ctrl.shift = 1'b1;
                  step_in       = step_ff + CNT_W'(1);
               end else if (!phase_ff && (head_lo < a_ff)) begin
                  // Left piece; the right piece, if any, follows next cycle.
                  bd_ctrl.shift = 1'b1;
                  emit_lo       = head_lo;
                  emit_hi       = a_ff;
                  wr_in         = wr_ff + CNT_W'(1);
                  if (head_hi > b_ff) begin
                     phase_in = 1'b1;
                  end else begin
                     st_ctrl.shift = 1'b1;
                     step_in       = step_ff + CNT_W'(1);
                  end
               end else begin
                  if (head_hi > b_ff) begin
                     bd_ctrl.shift = 1'b1;
                     emit_lo       = b_ff;
                     emit_hi       = head_hi;
                     wr_in         = wr_ff + CNT_W'(1);
                  end
                  phase_in      = 1'b0;
                  st_ctrl.shift = 1'b1;
                  step_in       = step_ff + CNT_W'(1);
               end
            end
         end
         ST_PAD: begin
            // Shift filler in until the new list sits at the head of the chain.
            if (wr_ff != CNT_MAX) begin
               bd_ctrl.shift = 1'b1;
               wr_in         = wr_ff + CNT_W'(1);
            end
         end
         ST_COPY: begin
            st_ctrl.load = 1'b1;
            cnt_in       = newn_ff;
            step_in      = '0;
         end
         ST_LIST: begin
            if (rsp_slot) begin
               rsp_valid_in = 1'b1;
               if (cnt_ff == '0) begin
                  rsp_user_in = 1'b0;
                  rsp_last_in = 1'b1;
                  rsp_data_in = OUT_W'({cnt_ff, {B{1'b0}}, {B{1'b0}}, {IDX_W{1'b0}},
                                        status_ff, chg_ff});
               end else begin
                  rsp_user_in   = 1'b1;
                  rsp_last_in   = (step_ff == cnt_ff - CNT_W'(1));
                  rsp_data_in   = OUT_W'({cnt_ff, head_hi, head_lo, step_ff[IDX_W-1:0],
                                          status_ff, chg_ff});
                  st_ctrl.shift = 1'b1;
                  step_in       = step_ff + CNT_W'(1);
               end
            end
         end
         ST_RESTORE: begin
            st_ctrl.shift = 1'b1;
            step_in       = (step_ff == CNT_LAST) ? '0 : step_ff + CNT_W'(1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      na_ff       <= na_in;
      nb_ff       <= nb_in;
      newn_ff     <= newn_in;
      step_ff     <= step_in;
      wr_ff       <= wr_in;
      keep_ff     <= keep_in;
      inside_ff   <= inside_in;
      any_ff      <= any_in;
      phase_ff    <= phase_in;
      placed_ff   <= placed_in;
      chg_ff      <= chg_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("stored count exceeds capacity");

   a_copy_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COPY |-> wr_ff == CNT_MAX)
      else $error("build chain not aligned at copy");

   a_build_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_BUILD |-> wr_ff <= newn_ff)
      else $error("rebuild emitted more intervals than counted");

   a_listing_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && $past(state_ff) == ST_RESTORE) |-> step_ff == '0)
      else $error("store chain not restored after listing");
`endif

endmodule

// File: test/tb_interval_set_merge_split_unit.sv
// Self-checking testbench for the interval set merge/split unit.
`timescale 1ns / 1ps

module tb_interval_set_merge_split_unit;
   import isms_pkg::*;

   localparam int MAX_IV = 16;
   localparam int BW = 32;
   localparam int REQ_DW = ((2*BW+7)/8)*8;
   localparam int RSP_DW = ((3+4+2*BW+5+7)/8)*8;
   localparam logic signed [BW-1:0] NEG_INF = {1'b1, {(BW-1){1'b0}}};
   localparam logic signed [BW-1:0] POS_INF = {1'b0, {(BW-1){1'b1}}};
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic              changed;
      status_type        status;
      logic              entry_valid;
      logic [3:0]        entry_index;
      logic signed [BW-1:0] entry_low;
      logic signed [BW-1:0] entry_high;
      logic [4:0]        entry_count;
      logic              last;
   } listing_type;

   typedef struct {
      req_kind_type      kind;
      logic              defined;
      logic signed [BW-1:0] lo;
      logic signed [BW-1:0] hi;
      logic              typed;   // expected status below is checked directly
      status_type        want_status;
   } request_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DW-1:0] req_tdata = '0;
   logic [2:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   interval_set_merge_split_unit #(.MAX_INTERVALS(MAX_IV), .BOUND_WIDTH(BW)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Shadow copy of the interval store, kept sorted and disjoint like the unit's own.
   logic signed [BW-1:0] set_lo [MAX_IV];
   logic signed [BW-1:0] set_hi [MAX_IV];
   int set_count = 0;

   listing_type pending_listings [$];
   int mismatch_count = 0;
   int listing_count = 0;
   int request_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_receiver = 1'b0;
   int typed_status_errors = 0;

   // Applies one request to the shadow store and queues the listing that follows it.
   function automatic status_type predict_request(req_kind_type kind, logic defined,
                                                  logic signed [BW-1:0] a,
                                                  logic signed [BW-1:0] b);
      logic signed [BW-1:0] nlo [MAX_IV+2];
      logic signed [BW-1:0] nhi [MAX_IV+2];
      logic signed [BW-1:0] ml, mh, ta, tb, na, nb;
      int n, i, j;
      bit chg, any, enclosed;
      status_type st;
      listing_type item;
      n = 0;
      chg = 0;
      any = 0;
      enclosed = 0;
      st = STATUS_OK;
      if (kind == REQ_CLEAR) begin
         chg = set_count != 0;
         set_count = 0;
      end else if (kind != REQ_UNUSED && defined) begin
         if (a > b) begin
            st = STATUS_ORDER;
         end else if (kind == REQ_ADD) begin
            for (i = 0; i < set_count; i++)
               if (set_lo[i] <= a && b <= set_hi[i]) enclosed = 1;
            if (!enclosed) begin
               na = a;
               nb = b;
               for (i = 0; i < set_count; i++) begin
                  if (a <= set_lo[i] && set_hi[i] <= b) continue;
                  if (a <= set_hi[i] && set_lo[i] <= b) begin
                     if (set_lo[i] < na) na = set_lo[i];
                     if (set_hi[i] > nb) nb = set_hi[i];
                  end else begin
                     nlo[n] = set_lo[i];
                     nhi[n] = set_hi[i];
                     n++;
                  end
               end
               if (n + 1 > MAX_IV) begin
                  st = STATUS_OVERFLOW;
               end else begin
                  nlo[n] = na;
                  nhi[n] = nb;
                  n++;
                  // Insertion sort by low bound, then high bound.
                  for (i = 1; i < n; i++) begin
                     ta = nlo[i];
                     tb = nhi[i];
                     j = i;
                     while (j > 0 && (nlo[j-1] > ta || (nlo[j-1] == ta && nhi[j-1] > tb))) begin
                        nlo[j] = nlo[j-1];
                        nhi[j] = nhi[j-1];
                        j--;
                     end
                     nlo[j] = ta;
                     nhi[j] = tb;
                  end
                  chg = 1;
               end
            end
         end else begin
            for (i = 0; i < set_count; i++) begin
               ml = set_lo[i] > a ? set_lo[i] : a;
               mh = set_hi[i] < b ? set_hi[i] : b;
               if (ml < mh) begin
                  any = 1;
                  if (set_lo[i] < a && n < MAX_IV+2) begin
                     nlo[n] = set_lo[i]; nhi[n] = a; n++;
                  end
                  if (set_hi[i] > b && n < MAX_IV+2) begin
                     nlo[n] = b; nhi[n] = set_hi[i]; n++;
                  end
               end else if (n < MAX_IV+2) begin
                  nlo[n] = set_lo[i]; nhi[n] = set_hi[i]; n++;
               end
            end
            if (any) begin
               if (n > MAX_IV) st = STATUS_OVERFLOW;
               else chg = 1;
            end
         end
         if (chg) begin
            for (i = 0; i < n; i++) begin
               set_lo[i] = nlo[i];
               set_hi[i] = nhi[i];
            end
            set_count = n;
         end
      end
      item.changed = chg;
      item.status = st;
      item.entry_count = set_count[4:0];
      if (set_count == 0) begin
         item.entry_valid = 0;
         item.entry_index = '0;
         item.entry_low = '0;
         item.entry_high = '0;
         item.last = 1;
         pending_listings.push_back(item);
      end
      for (i = 0; i < set_count; i++) begin
         item.entry_valid = 1;
         item.entry_index = i[3:0];
         item.entry_low = set_lo[i];
         item.entry_high = set_hi[i];
         item.last = (i + 1 == set_count);
         pending_listings.push_back(item);
      end
      return st;
   endfunction

   // Offers one request and waits for the handshake, predicting once it is accepted.
   task automatic send_request(req_kind_type kind, logic defined,
                               logic signed [BW-1:0] a, logic signed [BW-1:0] b,
                               logic typed = 0, status_type want = STATUS_OK);
      status_type got;
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= {defined, kind};
      req_tdata <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      req_tvalid <= 1'b0;
      got = predict_request(kind, defined, a, b);
      request_count++;
      if (typed && got != want) typed_status_errors++;
      // The unit is busy after a request, so the next offer
      // starts at the following edge.
      @(posedge clock);
   endtask

   // Receiver: random stalls, optional long hold-off, and the comparison itself.
   initial begin
      listing_type got, want;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.changed = rsp_tdata[0];
            got.status = rsp_tdata[2:1];
            got.entry_index = rsp_tdata[6:3];
            got.entry_low = rsp_tdata[7 +: BW];
            got.entry_high = rsp_tdata[7+BW +: BW];
            got.entry_count = rsp_tdata[7+2*BW +: 5];
            got.entry_valid = rsp_tuser;
            got.last = rsp_tlast;
            listing_count++;
            if (pending_listings.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("Unexpected response %p", got);
            end else begin
               want = pending_listings.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("Response mismatch: expected %p, got %p", want, got);
               end
            end
         end
         rsp_tready <= !reset && !hold_receiver && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d responses outstanding", pending_listings.size());
      $display("FAILURE");
      $finish;
   end

   function automatic logic signed [BW-1:0] random_bound(int span);
      case ($urandom_range(9))
         0: return NEG_INF;
         1: return POS_INF;
         2: return $urandom;
         default: return $signed($urandom_range(2*span)) - span;
      endcase
   endfunction

   task automatic wait_drained();
      while (pending_listings.size() != 0) @(posedge clock);
   endtask

   request_row_type directed [] = '{
      '{REQ_CLEAR,  1, 0, 0, 1, STATUS_OK},          // clear an empty set
      '{REQ_ADD,    0, 5, 9, 1, STATUS_OK},          // undefined add
      '{REQ_REMOVE, 0, 5, 9, 1, STATUS_OK},          // undefined remove
      '{REQ_ADD,    1, 9, 5, 1, STATUS_ORDER},       // low above high
      '{REQ_REMOVE, 1, 9, 5, 1, STATUS_ORDER},
      '{REQ_ADD,    1, 10, 20, 0, STATUS_OK},
      '{REQ_ADD,    1, 12, 15, 0, STATUS_OK},        // inside a stored interval
      '{REQ_ADD,    1, 20, 30, 0, STATUS_OK},        // touching merge
      '{REQ_ADD,    1, 40, 40, 0, STATUS_OK},        // single point
      '{REQ_REMOVE, 1, 30, 40, 0, STATUS_OK},        // touches only at edges
      '{REQ_REMOVE, 1, 15, 18, 0, STATUS_OK},        // split
      '{REQ_ADD,    1, NEG_INF, -100, 0, STATUS_OK},
      '{REQ_ADD,    1, 1000, POS_INF, 0, STATUS_OK},
      '{REQ_ADD,    1, 5, 50, 0, STATUS_OK},         // covers several
      '{REQ_UNUSED, 1, 0, 0, 1, STATUS_OK},          // unused type
      '{REQ_REMOVE, 1, NEG_INF, POS_INF, 1, STATUS_OK},
      '{REQ_ADD,    1, NEG_INF, POS_INF, 1, STATUS_OK},
      '{REQ_CLEAR,  0, -1, 1, 1, STATUS_OK}
   };

   initial begin
      int k;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_request(directed[i].kind, directed[i].defined, directed[i].lo, directed[i].hi,
                      directed[i].typed, directed[i].want_status);
      // Fill all sixteen cells, then push past capacity for both request kinds.
      for (k = 0; k < MAX_IV; k++) send_request(REQ_ADD, 1, k*10, k*10 + 4);
      send_request(REQ_ADD, 1, 500, 502, 1, STATUS_OVERFLOW);
      send_request(REQ_REMOVE, 1, 41, 41 + 0, 0);
      send_request(REQ_REMOVE, 1, 51, 52, 1, STATUS_OVERFLOW);
      wait_drained();

      // Long receiver hold-off while requests keep coming, so the unit backs up.
      hold_receiver = 1'b1;
      fork
         begin
            for (k = 0; k < 6; k++) send_request(REQ_ADD, 1, random_bound(300), POS_INF);
         end
         begin
            repeat (400) @(posedge clock);
            hold_receiver = 1'b0;
         end
      join

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 59 : 0;
         recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 35 : 0;
         for (k = 0; k < 45; k++) begin
            logic signed [BW-1:0] a, b;
            int pick;
            pick = $urandom_range(99);
            a = random_bound(200);
            b = (pick < 80) ? a + $urandom_range(60) : random_bound(200);
            if (b < a && pick < 80) b = POS_INF;
            if (pick < 50) send_request(REQ_ADD, 1, a, b);
            else if (pick < 85) send_request(REQ_REMOVE, 1, a, b);
            else if (pick < 90) send_request(REQ_CLEAR, 1'($urandom_range(1)), a, b);
            else if (pick < 93) send_request(REQ_UNUSED, 1'($urandom_range(1)), a, b);
            else send_request(req_kind_type'($urandom_range(1)), 1'($urandom_range(1)), a, b);
         end
         wait_drained();   // sender pauses until every listing has come back
      end

      recv_idle_pct = 0;
      repeat (200) @(posedge clock);
      mismatch_count += typed_status_errors;
      $display("Covered %0d requests (directed, capacity, back-pressure, random) and %0d responses.",
               request_count, listing_count);
      if (mismatch_count == 0 && pending_listings.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("FAILURE");
      end
      $finish;
   end

endmodule
